// ===== hw/rtl/sha1md_pkg.sv =====
// sha1md_pkg: shared types and constants for the SHA-1 digest core.
// Holds the controller/datapath command and status structs and the SHA-1 constants.
// No dependencies.
package sha1md_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned BLK_WORDS = 16;
    localparam int unsigned NUM_ROUNDS = 80;

    localparam logic [31:0] SHA1_IV [5] = '{
        32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
    };

    localparam logic [31:0] SHA1_K [4] = '{
        32'h5A82_7999, 32'h6ED9_EBA1, 32'h8F1B_BCDC, 32'hCA62_C1D6
    };

    localparam logic [31:0] PAD_WORD = 32'h8000_0000;

    typedef struct packed {
        logic load;         // accepted input beat goes into the block buffer
        logic pad_write;    // write one padding / length word
        logic round_start;  // copy chaining words into the working set
        logic round_step;   // run one round
        logic round_add;    // add working set into chaining words
        logic emit;         // capture digest, return to initial state
    } cmd_t;

    typedef struct packed {
        logic word_idx_last; // next input word lands in the last buffer slot
        logic pad_idx_last;  // next padding word lands in the last buffer slot
        logic len_hi_done;   // upper length word already written
        logic round_last;    // current round is the final one
    } sts_t;

endpackage

// ===== hw/rtl/sha1md_dp.sv =====
// sha1md_dp: SHA-1 datapath - block buffer / schedule window, round engine,
// chaining words, byte counter, padding pointer and digest output registers.
// Depends on sha1md_pkg.
module sha1md_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  sha1md_pkg::cmd_t    cmd,
    output sha1md_pkg::sts_t    sts,
    input  logic [31:0]         s_data_word,
    input  logic [2:0]          s_byte_count,
    input  logic                s_last,
    output logic [63:0]         m_digest_high,
    output logic [63:0]         m_digest_middle,
    output logic [31:0]         m_digest_low
);
    import sha1md_pkg::*;

    logic [31:0] w_reg [BLK_WORDS];
    logic [31:0] h_reg [5];
    logic [31:0] v_reg [5];
    logic [6:0]  rnd_reg, rnd_next;
    logic [60:0] cnt_reg, cnt_next;
    logic [3:0]  pidx_reg, pidx_next;
    logic        pad80_reg, pad80_next;
    logic        lenhi_reg, lenhi_next;
    logic [63:0] dig_high_reg;
    logic [63:0] dig_middle_reg;
    logic [31:0] dig_low_reg;

    logic [2:0]  n_eff;
    logic [31:0] in_word;
    logic [3:0]  in_idx;
    logic [63:0] bit_len;
    logic [31:0] pad_val;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_val;
    logic [31:0] w_new;
    logic [31:0] w_xor;

    assign n_eff   = (!s_last || s_byte_count > 3'd4) ? 3'd4 : s_byte_count;
    assign in_idx  = cnt_reg[5:2];
    assign bit_len = {cnt_reg, 3'b000};

    always_comb begin
        case (n_eff)
            3'd0:    in_word = PAD_WORD;
            3'd1:    in_word = {s_data_word[31:24], 8'h80, 16'h0000};
            3'd2:    in_word = {s_data_word[31:16], 8'h80, 8'h00};
            3'd3:    in_word = {s_data_word[31:8], 8'h80};
            default: in_word = s_data_word;
        endcase
    end

    always_comb begin
        if (pad80_reg) begin
            pad_val = PAD_WORD;
        end else if (pidx_reg == 4'd14) begin
            pad_val = bit_len[63:32];
        end else if (pidx_reg == 4'd15 && lenhi_reg) begin
            pad_val = bit_len[31:0];
        end else begin
            pad_val = '0;
        end
    end

    // round function and constant by round group
    always_comb begin
        if (rnd_reg < 7'd20) begin
            f_val = (v_reg[1] & v_reg[2]) | (~v_reg[1] & v_reg[3]);
            k_val = SHA1_K[0];
        end else if (rnd_reg < 7'd40) begin
            f_val = v_reg[1] ^ v_reg[2] ^ v_reg[3];
            k_val = SHA1_K[1];
        end else if (rnd_reg < 7'd60) begin
            f_val = (v_reg[1] & v_reg[2]) | (v_reg[1] & v_reg[3]) | (v_reg[2] & v_reg[3]);
            k_val = SHA1_K[2];
        end else begin
            f_val = v_reg[1] ^ v_reg[2] ^ v_reg[3];
            k_val = SHA1_K[3];
        end
    end

    assign t_val = {v_reg[0][26:0], v_reg[0][31:27]} + f_val + v_reg[4] + k_val + w_reg[0];
    assign w_xor = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign w_new = {w_xor[30:0], w_xor[31]};

    always_comb begin
        rnd_next   = rnd_reg;
        cnt_next   = cnt_reg;
        pidx_next  = pidx_reg;
        pad80_next = pad80_reg;
        lenhi_next = lenhi_reg;
        if (cmd.load) begin
            cnt_next = cnt_reg + 61'(n_eff);
            if (s_last) begin
                pidx_next  = in_idx + 4'd1;
                pad80_next = (n_eff == 3'd4);
            end
        end
        if (cmd.pad_write) begin
            pidx_next  = pidx_reg + 4'd1;
            pad80_next = 1'b0;
            if (!pad80_reg && pidx_reg == 4'd14) begin
                lenhi_next = 1'b1;
            end
        end
        if (cmd.round_start) begin
            rnd_next = '0;
        end else if (cmd.round_step) begin
            rnd_next = rnd_reg + 7'd1;
        end
        if (cmd.emit) begin
            cnt_next   = '0;
            pad80_next = 1'b0;
            lenhi_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rnd_reg   <= '0;
            cnt_reg   <= '0;
            pidx_reg  <= '0;
            pad80_reg <= 1'b0;
            lenhi_reg <= 1'b0;
        end else begin
            rnd_reg   <= rnd_next;
            cnt_reg   <= cnt_next;
            pidx_reg  <= pidx_next;
            pad80_reg <= pad80_next;
            lenhi_reg <= lenhi_next;
        end
    end

    // block buffer doubles as the message schedule window during rounds
    always_ff @(posedge aclk) begin
        if (cmd.round_step) begin
            for (int i = 0; i < BLK_WORDS - 1; i++) begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[BLK_WORDS - 1] <= w_new;
        end else if (cmd.load) begin
            w_reg[in_idx] <= in_word;
        end else if (cmd.pad_write) begin
            w_reg[pidx_reg] <= pad_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.round_start) begin
            for (int i = 0; i < 5; i++) begin
                v_reg[i] <= h_reg[i];
            end
        end else if (cmd.round_step) begin
            v_reg[0] <= t_val;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= {v_reg[1][1:0], v_reg[1][31:2]};
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 5; i++) begin
                h_reg[i] <= SHA1_IV[i];
            end
        end else if (cmd.emit) begin
            for (int i = 0; i < 5; i++) begin
                h_reg[i] <= SHA1_IV[i];
            end
        end else if (cmd.round_add) begin
            for (int i = 0; i < 5; i++) begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            dig_high_reg   <= {h_reg[0], h_reg[1]};
            dig_middle_reg <= {h_reg[2], h_reg[3]};
            dig_low_reg    <= h_reg[4];
        end
    end

    assign m_digest_high   = dig_high_reg;
    assign m_digest_middle = dig_middle_reg;
    assign m_digest_low    = dig_low_reg;

    assign sts.word_idx_last = (in_idx == 4'd15);
    assign sts.pad_idx_last  = (pidx_reg == 4'd15);
    assign sts.len_hi_done   = lenhi_reg;
    assign sts.round_last    = (rnd_reg == 7'(NUM_ROUNDS - 1));

endmodule

// ===== hw/rtl/sha1md_ctrl.sv =====
// sha1md_ctrl: SHA-1 sequencer - input acceptance, block compression passes,
// message padding and result handoff; drives the datapath by command struct.
// Depends on sha1md_pkg.
module sha1md_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_last,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  sha1md_pkg::sts_t    sts,
    output sha1md_pkg::cmd_t    cmd
);
    import sha1md_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_FINAL = 3'd4;

    localparam logic [1:0] RET_IDLE  = 2'd0;
    localparam logic [1:0] RET_PAD   = 2'd1;
    localparam logic [1:0] RET_FINAL = 2'd2;

    logic [2:0] state_reg, state_next;
    logic [1:0] ret_reg, ret_next;
    logic       out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (sts.word_idx_last) begin
                        cmd.round_start = 1'b1;
                        state_next      = ST_ROUND;
                        ret_next        = s_last ? RET_PAD : RET_IDLE;
                    end else if (s_last) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                cmd.pad_write = 1'b1;
                if (sts.pad_idx_last) begin
                    cmd.round_start = 1'b1;
                    state_next      = ST_ROUND;
                    ret_next        = sts.len_hi_done ? RET_FINAL : RET_PAD;
                end
            end
            ST_ROUND: begin
                cmd.round_step = 1'b1;
                if (sts.round_last) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.round_add = 1'b1;
                case (ret_reg)
                    RET_PAD:   state_next = ST_PAD;
                    RET_FINAL: state_next = ST_FINAL;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_FINAL: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ret_reg       <= RET_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_add_after_last_round: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ADD) |-> $past(sts.round_last))
        else $error("compression add without a completed round pass");

    a_emit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!out_valid_reg || m_ready))
        else $error("digest overwritten before the previous beat was taken");

    a_final_has_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINAL) |-> sts.len_hi_done)
        else $error("digest stage reached before length was padded in");

    a_last_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last) |=> (state_reg != ST_IDLE))
        else $error("final beat did not start padding");
`endif

endmodule

// ===== hw/rtl/sha1_message_digest_core.sv =====
// sha1_message_digest_core: SHA-1 digest of a byte message fed as big-endian words.
// Top level; instantiates sha1md_ctrl and sha1md_dp, depends on sha1md_pkg.
//
//   channel | ports                                          | direction
//   --------+------------------------------------------------+----------
//   input   | s_valid s_ready s_data_word s_byte_count s_last | in
//   result  | m_valid m_ready m_digest_high/middle/low        | out
//
// A beat is taken while the core is idle; the beat that fills word 15 of a block
// starts a pass of 80 rounds at one per cycle on the shared round engine, then
// the chaining add, and input waits with s_ready low during the pass.
// A final beat is followed by its padding words, written one per cycle, one or
// two such passes and the load of the digest into the output register.
// aresetn is synchronous; no clearing pass, the block is ready right after reset.
// A waiting digest does not stall input; the next digest holds in the final
// stage, with s_ready low, until m_ready takes the one before.
module sha1_message_digest_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_data_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_digest_high,
    output logic [63:0] m_digest_middle,
    output logic [31:0] m_digest_low
);
    import sha1md_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sha1md_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sha1md_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_data_word     (s_data_word),
        .s_byte_count    (s_byte_count),
        .s_last          (s_last),
        .m_digest_high   (m_digest_high),
        .m_digest_middle (m_digest_middle),
        .m_digest_low    (m_digest_low)
    );

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for sha1_message_digest_core.
// Sends whole messages as word beats and checks every digest against a SHA-1 model kept here.
// Depends only on the core RTL and its package.
module testbench;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        fin;
    } beat_t;

    typedef struct packed {
        logic [63:0] high;
        logic [63:0] middle;
        logic [31:0] low;
    } digest_t;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

    localparam logic [31:0] IV_WORD [5] = '{
        32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
    };
    localparam logic [31:0] ROUND_CONST [4] = '{
        32'h5A82_7999, 32'h6ED9_EBA1, 32'h8F1B_BCDC, 32'hCA62_C1D6
    };
    localparam int HOLD_CYCLES = 600;
    localparam int TAIL_CYCLES = 200;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_data_word = '0;
    logic [2:0]  s_byte_count = '0;
    logic        s_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_digest_high;
    logic [63:0] m_digest_middle;
    logic [31:0] m_digest_low;

    // running hash state
    logic [31:0] hash_words [5];
    logic [31:0] msg_block [16];
    logic [63:0] msg_bits;

    beat_t   beat_q [$];
    digest_t digest_q [$];

    int queued_total = 0;
    int accepted_cnt = 0;
    int errors = 0;
    int idle_pct = 0;
    bit quiet = 1'b0;
    int holds_asked = 0;
    int holds_granted = 0;
    int in_gap = 0;
    int rdy_gap = 0;
    int hold_left = 0;

    sha1_message_digest_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_word     (s_data_word),
        .s_byte_count    (s_byte_count),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_digest_high   (m_digest_high),
        .m_digest_middle (m_digest_middle),
        .m_digest_low    (m_digest_low)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // write one byte into the block; the 64th byte runs the 80 rounds
    function automatic void put_byte(int unsigned pos, logic [7:0] b);
        logic [31:0] w [16];
        logic [31:0] a, bb, c, d, e, f, t, x, k;
        int sh;
        sh = (3 - (pos & 3)) * 8;
        msg_block[(pos >> 2) & 15][sh +: 8] = b;
        if ((pos & 63) == 63) begin
            w = msg_block;
            a = hash_words[0];
            bb = hash_words[1];
            c = hash_words[2];
            d = hash_words[3];
            e = hash_words[4];
            for (int r = 0; r < 80; r++) begin
                if (r >= 16) begin
                    x = w[(r + 13) & 15] ^ w[(r + 8) & 15] ^ w[(r + 2) & 15] ^ w[r & 15];
                    w[r & 15] = {x[30:0], x[31]};
                end
                if (r < 20) begin
                    f = (bb & c) | (~bb & d);
                    k = ROUND_CONST[0];
                end else if (r < 40) begin
                    f = bb ^ c ^ d;
                    k = ROUND_CONST[1];
                end else if (r < 60) begin
                    f = (bb & c) | (bb & d) | (c & d);
                    k = ROUND_CONST[2];
                end else begin
                    f = bb ^ c ^ d;
                    k = ROUND_CONST[3];
                end
                t = {a[26:0], a[31:27]} + f + e + k + w[r & 15];
                e = d;
                d = c;
                c = {bb[1:0], bb[31:2]};
                bb = a;
                a = t;
            end
            hash_words[0] += a;
            hash_words[1] += bb;
            hash_words[2] += c;
            hash_words[3] += d;
            hash_words[4] += e;
        end
    endfunction

    // absorb one accepted beat; returns 1 with the digest on a final beat
    function automatic bit absorb_beat(logic [31:0] word, logic [2:0] nbytes, logic fin,
                                       output digest_t dg);
        int unsigned n, pos;
        logic [63:0] len;
        dg = '0;
        n = (!fin || nbytes > 3'd4) ? 4 : nbytes;
        for (int i = 0; i < n; i++) begin
            pos = msg_bits[8:3];
            msg_bits += 64'd8;
            put_byte(pos, word[31 - 8 * i -: 8]);
        end
        if (!fin)
            return 1'b0;
        len = msg_bits;
        pos = len[8:3];
        put_byte(pos, 8'h80);
        pos = (pos + 1) & 63;
        while (pos != 56) begin
            put_byte(pos, 8'h00);
            pos = (pos + 1) & 63;
        end
        for (int i = 0; i < 8; i++) begin
            put_byte(pos, len[63 - 8 * i -: 8]);
            pos++;
        end
        dg.high = {hash_words[0], hash_words[1]};
        dg.middle = {hash_words[2], hash_words[3]};
        dg.low = hash_words[4];
        hash_words = IV_WORD;
        msg_bits = '0;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t %s: got %h want %h", $time, what, got, want);
        errors++;
    endtask

    task automatic push_beat(logic [31:0] word, logic [2:0] nbytes, logic fin);
        beat_t b;
        b.word = word;
        b.nbytes = nbytes;
        b.fin = fin;
        beat_q.push_back(b);
        queued_total++;
    endtask

    // a whole message of len_bytes bytes; unused bytes follow the fill and ignored counts are random
    task automatic queue_message(int len_bytes, fill_e fill);
        int nfull, rem;
        logic [31:0] word;
        nfull = len_bytes / 4;
        rem = len_bytes % 4;
        if (rem == 0 && nfull > 0 && $urandom_range(0, 1))
            nfull--;
        for (int i = 0; i <= nfull; i++) begin
            case (fill)
                FILL_ZERO: word = 32'h0;
                FILL_ONES: word = 32'hFFFF_FFFF;
                default:   word = $urandom;
            endcase
            if (i < nfull)
                push_beat(word, 3'($urandom_range(0, 7)), 1'b0);
            else if (nfull * 4 == len_bytes)
                push_beat(word, 3'd0, 1'b1);
            else if (rem == 0)
                push_beat(word, 3'($urandom_range(4, 7)), 1'b1);
            else
                push_beat(word, 3'(rem), 1'b1);
        end
    endtask

    always @(posedge aclk) begin : driver
        beat_t b;
        digest_t dg;
        if (!aresetn) begin
            s_valid <= 1'b0;
            in_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                accepted_cnt++;
                if (absorb_beat(s_data_word, s_byte_count, s_last, dg))
                    digest_q.push_back(dg);
            end
            if (!s_valid || s_ready) begin
                if (in_gap > 0) begin
                    s_valid <= 1'b0;
                    in_gap <= in_gap - 1;
                end else if (beat_q.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
                    s_valid <= 1'b0;
                    in_gap <= $urandom_range(0, 14);
                end else begin
                    b = beat_q.pop_front();
                    s_valid <= 1'b1;
                    s_data_word <= b.word;
                    s_byte_count <= b.nbytes;
                    s_last <= b.fin;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rdy_gap <= 0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_granted != holds_asked) begin
            m_ready <= 1'b0;
            holds_granted <= holds_granted + 1;
            hold_left <= HOLD_CYCLES;
        end else if (rdy_gap > 0) begin
            m_ready <= 1'b0;
            rdy_gap <= rdy_gap - 1;
        end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            m_ready <= 1'b0;
            rdy_gap <= $urandom_range(0, 14);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : monitor
        digest_t want;
        if (aresetn && m_valid && m_ready) begin
            if (digest_q.size() == 0) begin
                flag_mismatch("unexpected digest, high word", m_digest_high, '0);
            end else begin
                want = digest_q.pop_front();
                if (m_digest_high !== want.high)
                    flag_mismatch("digest_high", m_digest_high, want.high);
                if (m_digest_middle !== want.middle)
                    flag_mismatch("digest_middle", m_digest_middle, want.middle);
                if (m_digest_low !== want.low)
                    flag_mismatch("digest_low", 64'(m_digest_low), 64'(want.low));
            end
        end
    end

    initial begin
        #5_000_000;
        $display("sha1_message_digest_core: mismatch");
        $finish;
    end

    initial begin
        int len_bytes;
        fill_e fill;
        hash_words = IV_WORD;
        msg_block = '{default: '0};
        msg_bits = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty message, "abc", every final count, zero and ones data
        queue_message(0, FILL_RANDOM);
        push_beat(32'h6162_63A5, 3'd3, 1'b1);
        push_beat($urandom, 3'd1, 1'b1);
        push_beat($urandom, 3'd2, 1'b1);
        push_beat($urandom, 3'd4, 1'b1);
        push_beat($urandom, 3'd5, 1'b1);
        push_beat($urandom, 3'd6, 1'b1);
        push_beat($urandom, 3'd7, 1'b1);
        push_beat($urandom, 3'd0, 1'b0);
        push_beat($urandom, 3'd2, 1'b1);
        queue_message(8, FILL_ZERO);
        queue_message(8, FILL_ONES);
        push_beat(32'hFFFF_FFFF, 3'd7, 1'b0);
        push_beat(32'h0000_0000, 3'd0, 1'b1);

        idle_pct = 30;
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                // sender waits for every digest, then the receiver holds off
                // while short messages pile up behind it
                while (accepted_cnt != queued_total || digest_q.size() != 0)
                    @(posedge aclk);
                holds_asked++;
                for (int i = 0; i < 12; i++)
                    queue_message($urandom_range(0, 8), FILL_RANDOM);
            end
            if (phase == 2) begin
                while (queued_total - accepted_cnt > 20)
                    @(posedge aclk);
                quiet = 1'b1;
            end
            while (queued_total < (phase == 0 ? 200 : (phase == 1 ? 390 : 450))) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: len_bytes = $urandom_range(0, 12);
                    5, 6, 7: len_bytes = ($urandom_range(0, 1) ? 52 : 116)
                                         + $urandom_range(0, 14);
                    default: len_bytes = $urandom_range(13, 200);
                endcase
                case ($urandom_range(0, 9))
                    0: fill = FILL_ZERO;
                    1: fill = FILL_ONES;
                    default: fill = FILL_RANDOM;
                endcase
                queue_message(len_bytes, fill);
            end
        end

        while (accepted_cnt != queued_total)
            @(posedge aclk);
        while (digest_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("sha1_message_digest_core: match");
        else
            $display("sha1_message_digest_core: mismatch");
        $finish;
    end

endmodule
